FILE: rtl/ridat_pkg.sv
// Package for the request ID allocator with timeout.
// Holds field widths, operation codes, result kinds and the delay reset value.
// No dependencies.
`timescale 1ns / 1ps

package ridat_pkg;

  localparam int unsigned FuncW = 2;
  localparam int unsigned IdW   = 6;
  localparam int unsigned TimeW = 32;
  localparam int unsigned KindW = 3;
  localparam int unsigned DlyW  = 16;

  // Operation codes of a request
  localparam logic [FuncW-1:0] FUNC_START  = 2'd0;
  localparam logic [FuncW-1:0] FUNC_END    = 2'd1;
  localparam logic [FuncW-1:0] FUNC_TICK   = 2'd2;
  localparam logic [FuncW-1:0] FUNC_LOOKUP = 2'd3;

  // Kinds of a response
  localparam logic [KindW-1:0] KIND_STARTED    = 3'd0;
  localparam logic [KindW-1:0] KIND_START_FULL = 3'd1;
  localparam logic [KindW-1:0] KIND_END_ACK    = 3'd2;
  localparam logic [KindW-1:0] KIND_LOOKUP     = 3'd3;
  localparam logic [KindW-1:0] KIND_TIMEOUT    = 3'd4;

  localparam logic [DlyW-1:0] DELAY_RST = 16'd5;

endpackage

FILE: rtl/ridat_req_if.sv
// Request channel of the request ID allocator.
// Carries valid, ready and the request fields; depends on ridat_pkg.
`timescale 1ns / 1ps

interface ridat_req_if
  import ridat_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [FuncW-1:0] func;
  logic [IdW-1:0]   request_id;
  logic [TimeW-1:0] now_time;

  modport source (output valid, func, request_id, now_time, input ready);
  modport sink   (input valid, func, request_id, now_time, output ready);
endinterface

FILE: rtl/ridat_rsp_if.sv
// Response channel of the request ID allocator.
// Carries valid, ready and the response fields; depends on ridat_pkg.
`timescale 1ns / 1ps

interface ridat_rsp_if
  import ridat_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [KindW-1:0] kind;
  logic [IdW-1:0]   result_id;
  logic             found;
  logic             is_active;
  logic             is_timed_out;
  logic             last;

  modport source (output valid, kind, result_id, found, is_active, is_timed_out, last,
                  input ready);
  modport sink   (input valid, kind, result_id, found, is_active, is_timed_out, last,
                  output ready);
endinterface

FILE: rtl/ridat_alu.sv
// Shared 32-bit adder of the allocator: forms an expiry sum or an
// unsigned greater-than compare on one carry chain. Depends on ridat_pkg.
`timescale 1ns / 1ps

module ridat_alu
  import ridat_pkg::*;
(
  input  logic             op_add_i,
  input  logic [TimeW-1:0] a_i,
  input  logic [TimeW-1:0] b_i,
  output logic [TimeW-1:0] sum_o,
  output logic             gt_o
);

  logic [TimeW-1:0] x;
  logic [TimeW-1:0] y;
  logic [TimeW:0]   res;

  // Add a + b, or form b - a whose missing carry means a > b
  assign x   = op_add_i ? a_i : b_i;
  assign y   = op_add_i ? b_i : ~a_i;
  assign res = {1'b0, x} + {1'b0, y} + {{TimeW{1'b0}}, ~op_add_i};

  assign sum_o = res[TimeW-1:0];
  assign gt_o  = ~res[TimeW];

endmodule

FILE: rtl/request_id_allocator_timeout.sv
// Request ID allocator with timeout: lowest-free ID table with expiry scan.
// Start checks one slot per cycle, while the response register is free, for the
// lowest free ID. End and lookup check the one named ID. Tick reads each slot's
// expiry through a registered read, then runs the shared compare; it waits while responses stall.
// One request at a time; the response register frees the input side early.
// Reset (async, active low) empties the table and sets the delay to 5.
`timescale 1ns / 1ps

module request_id_allocator_timeout
  import ridat_pkg::*;
#(
  parameter int unsigned MAX_REQUESTS = 32
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [DlyW-1:0] cfg_wdata_i,
  ridat_req_if.sink       req_i,
  ridat_rsp_if.source     rsp_o
);

  localparam int unsigned IdxW = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(MAX_REQUESTS - 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ALLOC = 3'd1;
  localparam logic [2:0] S_QUERY = 3'd2;
  localparam logic [2:0] S_TRD   = 3'd3;
  localparam logic [2:0] S_TCMP  = 3'd4;
  localparam logic [2:0] S_TEND  = 3'd5;

  logic [2:0]              state_q, state_d;
  logic [IdxW-1:0]         idx_q, idx_d;
  logic [FuncW-1:0]        func_q;
  logic [IdW-1:0]          rid_q;
  logic [TimeW-1:0]        now_q;
  logic [DlyW-1:0]         delay_q;
  logic [MAX_REQUESTS-1:0] valid_q, valid_d;
  logic [MAX_REQUESTS-1:0] active_q, active_d;
  logic [MAX_REQUESTS-1:0] expired_q, expired_d;
  logic                    pend_q, pend_d;
  logic [IdW-1:0]          pend_id_q, pend_id_d;

  logic [TimeW-1:0]        expiry_mem [MAX_REQUESTS];
  logic [TimeW-1:0]        rdata_q;
  logic                    mem_we, mem_re;

  logic                    rsp_valid_q, rsp_valid_d;
  logic [KindW-1:0]        rsp_kind_q, rsp_kind_d;
  logic [IdW-1:0]          rsp_id_q, rsp_id_d;
  logic                    rsp_found_q, rsp_found_d;
  logic                    rsp_act_q, rsp_act_d;
  logic                    rsp_tmo_q, rsp_tmo_d;
  logic                    rsp_last_q, rsp_last_d;

  logic                    op_add;
  logic [TimeW-1:0]        alu_sum;
  logic                    alu_gt;
  logic                    out_free;
  logic                    in_acc;
  logic [IdW-1:0]          idx_id;
  logic                    rid_ok;
  logic [IdxW-1:0]         qslot;
  logic                    present;
  logic                    hit;
  logic                    event_hit;

  // Shared adder: expiry sum during allocation, compare during the scan
  assign op_add = (state_q == S_ALLOC);

  ridat_alu u_alu (
    .op_add_i (op_add),
    .a_i      (now_q),
    .b_i      (op_add ? {{(TimeW-DlyW){1'b0}}, delay_q} : rdata_q),
    .sum_o    (alu_sum),
    .gt_o     (alu_gt)
  );

  assign out_free = ~rsp_valid_q | rsp_o.ready;
  assign in_acc   = req_i.valid & req_i.ready;
  assign req_i.ready = (state_q == S_IDLE);

  assign idx_id  = IdW'({1'b0, idx_q} + (IdxW + 1)'(1));
  assign rid_ok  = (rid_q != '0) && ({1'b0, rid_q} <= (IdW + 1)'(MAX_REQUESTS));
  assign qslot   = IdxW'(rid_q - IdW'(1));
  assign present = rid_ok & valid_q[qslot];

  assign hit       = valid_q[idx_q] & alu_gt;
  assign event_hit = hit & active_q[idx_q] & ~expired_q[idx_q];

  // Sequencer
  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    valid_d     = valid_q;
    active_d    = active_q;
    expired_d   = expired_q;
    pend_d      = pend_q;
    pend_id_d   = pend_id_q;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    rsp_valid_d = rsp_valid_q & ~rsp_o.ready;
    rsp_kind_d  = rsp_kind_q;
    rsp_id_d    = rsp_id_q;
    rsp_found_d = rsp_found_q;
    rsp_act_d   = rsp_act_q;
    rsp_tmo_d   = rsp_tmo_q;
    rsp_last_d  = rsp_last_q;

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          idx_d = '0;
          case (req_i.func)
            FUNC_START: state_d = S_ALLOC;
            FUNC_TICK:  state_d = S_TRD;
            default:    state_d = S_QUERY;
          endcase
        end
      end

      // Check one slot per cycle, while the response register is free, for the lowest free ID
      S_ALLOC: begin
        if (out_free) begin
          if (!valid_q[idx_q]) begin
            valid_d[idx_q]   = 1'b1;
            active_d[idx_q]  = 1'b1;
            expired_d[idx_q] = 1'b0;
            mem_we      = 1'b1;
            rsp_valid_d = 1'b1;
            rsp_kind_d  = KIND_STARTED;
            rsp_id_d    = idx_id;
            rsp_found_d = 1'b1;
            rsp_act_d   = 1'b1;
            rsp_tmo_d   = 1'b0;
            rsp_last_d  = 1'b1;
            state_d     = S_IDLE;
          end else if (idx_q == LastIdx) begin
            rsp_valid_d = 1'b1;
            rsp_kind_d  = KIND_START_FULL;
            rsp_id_d    = '0;
            rsp_found_d = 1'b0;
            rsp_act_d   = 1'b0;
            rsp_tmo_d   = 1'b0;
            rsp_last_d  = 1'b1;
            state_d     = S_IDLE;
          end else begin
            idx_d = idx_q + IdxW'(1);
          end
        end
      end

      // End or lookup of one named ID
      S_QUERY: begin
        if (out_free) begin
          if (present && func_q == FUNC_END) begin
            active_d[qslot] = 1'b0;
          end
          rsp_valid_d = 1'b1;
          rsp_kind_d  = (func_q == FUNC_END) ? KIND_END_ACK : KIND_LOOKUP;
          rsp_id_d    = rid_q;
          rsp_found_d = present;
          rsp_act_d   = present & (func_q != FUNC_END) & active_q[qslot];
          rsp_tmo_d   = present & expired_q[qslot];
          rsp_last_d  = 1'b1;
          state_d     = S_IDLE;
        end
      end

      // Fetch the expiry of the current slot
      S_TRD: begin
        mem_re  = 1'b1;
        state_d = S_TCMP;
      end

      // Compare, update marks, hold one event back to tag the final one
      S_TCMP: begin
        if (!(event_hit && pend_q && !out_free)) begin
          if (event_hit) begin
            if (pend_q) begin
              rsp_valid_d = 1'b1;
              rsp_kind_d  = KIND_TIMEOUT;
              rsp_id_d    = pend_id_q;
              rsp_found_d = 1'b1;
              rsp_act_d   = 1'b1;
              rsp_tmo_d   = 1'b0;
              rsp_last_d  = 1'b0;
            end
            pend_d    = 1'b1;
            pend_id_d = idx_id;
          end
          if (hit) begin
            if (!active_q[idx_q]) begin
              valid_d[idx_q]   = 1'b0;
              expired_d[idx_q] = 1'b0;
            end else begin
              expired_d[idx_q] = 1'b1;
            end
          end
          if (idx_q == LastIdx) begin
            state_d = S_TEND;
          end else begin
            idx_d   = idx_q + IdxW'(1);
            state_d = S_TRD;
          end
        end
      end

      // Flush the held event as the final response
      S_TEND: begin
        if (!pend_q) begin
          state_d = S_IDLE;
        end else if (out_free) begin
          rsp_valid_d = 1'b1;
          rsp_kind_d  = KIND_TIMEOUT;
          rsp_id_d    = pend_id_q;
          rsp_found_d = 1'b1;
          rsp_act_d   = 1'b1;
          rsp_tmo_d   = 1'b0;
          rsp_last_d  = 1'b1;
          pend_d      = 1'b0;
          state_d     = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      idx_q       <= '0;
      valid_q     <= '0;
      active_q    <= '0;
      expired_q   <= '0;
      pend_q      <= 1'b0;
      rsp_valid_q <= 1'b0;
      delay_q     <= DELAY_RST;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      valid_q     <= valid_d;
      active_q    <= active_d;
      expired_q   <= expired_d;
      pend_q      <= pend_d;
      rsp_valid_q <= rsp_valid_d;
      if (cfg_we_i) begin
        delay_q <= cfg_wdata_i;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      func_q <= req_i.func;
      rid_q  <= req_i.request_id;
      now_q  <= req_i.now_time;
    end
    pend_id_q   <= pend_id_d;
    rsp_kind_q  <= rsp_kind_d;
    rsp_id_q    <= rsp_id_d;
    rsp_found_q <= rsp_found_d;
    rsp_act_q   <= rsp_act_d;
    rsp_tmo_q   <= rsp_tmo_d;
    rsp_last_q  <= rsp_last_d;
  end

  // Expiry memory: one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      expiry_mem[idx_q] <= alu_sum;
    end
    if (mem_re) begin
      rdata_q <= expiry_mem[idx_q];
    end
  end

  assign rsp_o.valid        = rsp_valid_q;
  assign rsp_o.kind         = rsp_kind_q;
  assign rsp_o.result_id    = rsp_id_q;
  assign rsp_o.found        = rsp_found_q;
  assign rsp_o.is_active    = rsp_act_q;
  assign rsp_o.is_timed_out = rsp_tmo_q;
  assign rsp_o.last         = rsp_last_q;

endmodule

FILE: test/request_id_allocator_timeout_checker.sv
// Scoreboard for the request ID allocator with timeout: watches both channels,
// keeps its own copy of the ID table and compares every response in order.
// Depends on ridat_pkg, ridat_req_if and ridat_rsp_if.
`timescale 1ns / 1ps

module request_id_allocator_timeout_checker
  import ridat_pkg::*;
#(
  parameter int unsigned NumIds = 32
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [DlyW-1:0] cfg_wdata_i,
  ridat_req_if            req_i,
  ridat_rsp_if            rsp_i,
  output int unsigned     fail_count_o,
  output int unsigned     pending_o
);

  localparam int unsigned MaxReports = 20;

  typedef struct packed {
    logic [KindW-1:0] kind;
    logic [IdW-1:0]   id;
    logic             found;
    logic             active;
    logic             timed_out;
    logic             last;
  } id_result_t;

  // Responses the table model says are still to come, oldest first
  id_result_t expected_rsp_q[$];

  // Model of the ID table; ID n lives in slot n-1
  logic [NumIds-1:0] id_valid;
  logic [NumIds-1:0] id_active;
  logic [NumIds-1:0] id_timed_out;
  logic [TimeW-1:0]  id_expiry [NumIds];
  logic [DlyW-1:0]   timeout_delay;

  function automatic id_result_t make_result(input logic [KindW-1:0] kind,
                                             input logic [IdW-1:0] id,
                                             input logic found,
                                             input logic active,
                                             input logic timed_out,
                                             input logic last);
    id_result_t r;
    r.kind      = kind;
    r.id        = id;
    r.found     = found;
    r.active    = active;
    r.timed_out = timed_out;
    r.last      = last;
    return r;
  endfunction

  // Update the table for one request and queue the responses it causes
  function automatic void predict_id_table(input logic [FuncW-1:0] func,
                                           input logic [IdW-1:0] rid,
                                           input logic [TimeW-1:0] now);
    int         slot;
    int         n_events;
    logic       present;
    id_result_t tail;
    slot     = -1;
    n_events = 0;
    case (func)
      FUNC_START: begin
        // Take the lowest free slot
        for (int i = NumIds - 1; i >= 0; i--) begin
          if (!id_valid[i]) slot = i;
        end
        if (slot < 0) begin
          expected_rsp_q.push_back(make_result(KIND_START_FULL, '0, 1'b0, 1'b0, 1'b0, 1'b1));
        end else begin
          id_valid[slot]     = 1'b1;
          id_active[slot]    = 1'b1;
          id_timed_out[slot] = 1'b0;
          id_expiry[slot]    = now + TimeW'(timeout_delay);
          expected_rsp_q.push_back(make_result(KIND_STARTED, IdW'(slot + 1), 1'b1, 1'b1,
                                               1'b0, 1'b1));
        end
      end
      FUNC_TICK: begin
        // Scan in ascending ID order; only expired entries are touched
        for (int i = 0; i < NumIds; i++) begin
          if (id_valid[i] && now > id_expiry[i]) begin
            if (id_active[i] && !id_timed_out[i]) begin
              expected_rsp_q.push_back(make_result(KIND_TIMEOUT, IdW'(i + 1), 1'b1, 1'b1,
                                                   1'b0, 1'b0));
              n_events++;
            end
            if (!id_active[i]) begin
              id_valid[i]     = 1'b0;
              id_timed_out[i] = 1'b0;
            end else begin
              id_timed_out[i] = 1'b1;
            end
          end
        end
        if (n_events > 0) begin
          tail      = expected_rsp_q.pop_back();
          tail.last = 1'b1;
          expected_rsp_q.push_back(tail);
        end
      end
      default: begin
        // End and lookup: IDs outside 1..NumIds are never present
        slot    = int'(rid) - 1;
        present = (rid >= 1 && rid <= NumIds) ? id_valid[slot] : 1'b0;
        if (present && func == FUNC_END) id_active[slot] = 1'b0;
        expected_rsp_q.push_back(make_result(
            (func == FUNC_END) ? KIND_END_ACK : KIND_LOOKUP, rid, present,
            present ? id_active[slot] : 1'b0, present ? id_timed_out[slot] : 1'b0, 1'b1));
      end
    endcase
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    id_result_t exp_rsp;
    id_result_t got_rsp;
    if (!rst_ni) begin
      expected_rsp_q.delete();
      id_valid      = '0;
      id_active     = '0;
      id_timed_out  = '0;
      timeout_delay = DELAY_RST;
      for (int i = 0; i < NumIds; i++) id_expiry[i] = '0;
      fail_count_o  = 0;
      pending_o     = 0;
    end else begin
      if (cfg_we_i) timeout_delay = cfg_wdata_i;

      // Check the response first: it can never belong to a request taken at this edge
      if (rsp_i.valid && rsp_i.ready) begin
        got_rsp = make_result(rsp_i.kind, rsp_i.result_id, rsp_i.found, rsp_i.is_active,
                              rsp_i.is_timed_out, rsp_i.last);
        if (expected_rsp_q.size() == 0) begin
          if (fail_count_o < MaxReports) begin
            $display("%0t: unexpected response kind %0d id %0d found %0b active %0b",
                     $time, got_rsp.kind, got_rsp.id, got_rsp.found, got_rsp.active,
                     " timed_out %0b last %0b", got_rsp.timed_out, got_rsp.last);
          end
          fail_count_o++;
        end else begin
          exp_rsp = expected_rsp_q.pop_front();
          if (got_rsp !== exp_rsp) begin
            if (fail_count_o < MaxReports) begin
              $display("%0t: response mismatch: expected kind %0d id %0d found %0b",
                       $time, exp_rsp.kind, exp_rsp.id, exp_rsp.found,
                       " active %0b timed_out %0b last %0b",
                       exp_rsp.active, exp_rsp.timed_out, exp_rsp.last);
              $display("%0t:                    actual   kind %0d id %0d found %0b",
                       $time, got_rsp.kind, got_rsp.id, got_rsp.found,
                       " active %0b timed_out %0b last %0b",
                       got_rsp.active, got_rsp.timed_out, got_rsp.last);
            end
            fail_count_o++;
          end
        end
      end

      if (req_i.valid && req_i.ready) begin
        predict_id_table(req_i.func, req_i.request_id, req_i.now_time);
      end
      pending_o = expected_rsp_q.size();
    end
  end

endmodule

FILE: test/request_id_allocator_timeout_tb.sv
// Top of the request ID allocator testbench: clock, reset, request and
// response traffic, delay register writes, watchdog and the final verdict.
// Depends on ridat_pkg, both channel interfaces, the block and its checker.
`timescale 1ns / 1ps

module request_id_allocator_timeout_tb;
  import ridat_pkg::*;

  localparam int unsigned NumIds       = 32;
  localparam int unsigned SettleCycles = 120;
  localparam int unsigned StallLimit   = 5000;
  localparam int unsigned HoldCycles   = 400;
  localparam int unsigned PhaseItems   = 70;

  logic            clk_i = 1'b0;
  logic            rst_ni;
  logic            cfg_we;
  logic [DlyW-1:0] cfg_wdata;

  int unsigned      send_idle_pct  = 0;
  int unsigned      recv_stall_pct = 0;
  int unsigned      hold_requests  = 0;
  int unsigned      quiet_cycles   = 0;
  int unsigned      fail_count;
  int unsigned      pending;
  logic [DlyW-1:0]  delay_setting;
  logic [TimeW-1:0] now_ticks;

  ridat_req_if req_if ();
  ridat_rsp_if rsp_if ();

  always #1 clk_i = ~clk_i;

  request_id_allocator_timeout #(
    .MAX_REQUESTS(NumIds)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .req_i      (req_if),
    .rsp_o      (rsp_if)
  );

  request_id_allocator_timeout_checker #(
    .NumIds(NumIds)
  ) u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .req_i       (req_if),
    .rsp_i       (rsp_if),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  // Drive response ready: a requested hold-off first, then random stalls
  initial begin : rsp_ready_drive
    int unsigned hold_left;
    int unsigned hold_seen;
    hold_left     = 0;
    hold_seen     = 0;
    rsp_if.ready  = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_requests != hold_seen) begin
        hold_seen = hold_requests;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        rsp_if.ready = 1'b0;
        hold_left--;
      end else begin
        rsp_if.ready = ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  // Abort when no transaction moves on either channel for too long
  always @(posedge clk_i) begin
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == StallLimit) begin
      $display("request_id_allocator_timeout_tb NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one request, entered and left at a falling edge; valid stays up afterwards
  task automatic send_req(input logic [FuncW-1:0] func, input logic [IdW-1:0] rid,
                          input logic [TimeW-1:0] now);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      req_if.valid = 1'b0;
      @(negedge clk_i);
    end
    req_if.valid      = 1'b1;
    req_if.func       = func;
    req_if.request_id = rid;
    req_if.now_time   = now;
    do @(posedge clk_i); while (!req_if.ready);
    @(negedge clk_i);
  endtask

  // Drop valid, wait for every expected response, then let a silent tick finish
  task automatic wait_idle();
    req_if.valid = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic write_delay(input logic [DlyW-1:0] value);
    cfg_we        = 1'b1;
    cfg_wdata     = value;
    delay_setting = value;
    @(negedge clk_i);
    cfg_we        = 1'b0;
  endtask

  // Mostly well-formed traffic with time moving forward on the scale of the delay
  task automatic random_traffic(input int unsigned n_items);
    logic [FuncW-1:0] func;
    logic [IdW-1:0]   rid;
    int unsigned      pick;
    int unsigned      span;
    span = int'(delay_setting) / 4 + 3;
    for (int unsigned k = 0; k < n_items; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 35)      func = FUNC_START;
      else if (pick < 55) func = FUNC_END;
      else if (pick < 80) func = FUNC_TICK;
      else                func = FUNC_LOOKUP;
      if ($urandom_range(0, 9) == 0) rid = IdW'($urandom);
      else                           rid = IdW'($urandom_range(1, NumIds));
      if ($urandom_range(0, 29) == 0) now_ticks = $urandom;
      else                            now_ticks = now_ticks + $urandom_range(0, span);
      send_req(func, rid, now_ticks);
    end
  endtask

  task automatic run_phase(input logic [DlyW-1:0] delay, input int unsigned idle_pct,
                           input int unsigned stall_pct, input logic [TimeW-1:0] base);
    wait_idle();
    write_delay(delay);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    now_ticks      = base;
    random_traffic(PhaseItems);
  endtask

  initial begin
    logic [TimeW-1:0] t0;
    rst_ni            = 1'b0;
    cfg_we            = 1'b0;
    cfg_wdata         = '0;
    delay_setting     = DELAY_RST;
    now_ticks         = '0;
    req_if.valid      = 1'b0;
    req_if.func       = FUNC_START;
    req_if.request_id = '0;
    req_if.now_time   = '0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: invalid IDs, empty tick, expiry wrap, single events, removal, reuse
    send_req(FUNC_LOOKUP, 6'd0, 32'd0);
    send_req(FUNC_LOOKUP, 6'd63, 32'd0);
    send_req(FUNC_END, 6'd33, 32'd0);
    send_req(FUNC_TICK, 6'd0, 32'd100);
    send_req(FUNC_START, 6'd0, 32'hFFFF_FFFE);
    send_req(FUNC_START, 6'd0, 32'hFFFF_FFFF);
    send_req(FUNC_LOOKUP, 6'd1, 32'd0);
    send_req(FUNC_TICK, 6'd0, 32'd3);
    send_req(FUNC_TICK, 6'd0, 32'd4);
    send_req(FUNC_TICK, 6'd0, 32'd5);
    send_req(FUNC_LOOKUP, 6'd1, 32'd5);
    send_req(FUNC_END, 6'd1, 32'd5);
    send_req(FUNC_END, 6'd1, 32'd5);
    send_req(FUNC_TICK, 6'd0, 32'd6);
    send_req(FUNC_LOOKUP, 6'd1, 32'd6);
    send_req(FUNC_START, 6'd0, 32'd10);
    send_req(FUNC_LOOKUP, 6'd1, 32'd10);
    send_req(FUNC_END, 6'd2, 32'd10);
    send_req(FUNC_START, 6'd0, 32'd10);
    send_req(FUNC_TICK, 6'd0, 32'd16);
    send_req(FUNC_LOOKUP, 6'd2, 32'd16);
    send_req(FUNC_LOOKUP, 6'd32, 32'd16);
    send_req(FUNC_END, 6'd32, 32'd16);
    send_req(FUNC_START, 6'h3F, 32'd16);

    // Random phases over delay extremes and handshake pressure
    run_phase(16'd0, 0, 0, 32'hFFFF_FF00);
    run_phase(16'hFFFF, 81, 0, $urandom);
    run_phase(DlyW'($urandom_range(1, 40)), 0, 81, $urandom);
    run_phase(DlyW'($urandom_range(1, 200)), 27, 27, $urandom);

    // Hold responses off while starts pile up, so the table fills and input stalls
    wait_idle();
    write_delay(16'hFFFF);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    t0             = $urandom;
    @(posedge clk_i);
    hold_requests++;
    @(negedge clk_i);
    for (int unsigned k = 0; k < NumIds + 8; k++) send_req(FUNC_START, '0, t0);
    for (int unsigned k = 0; k < 4; k++) begin
      send_req(FUNC_LOOKUP, IdW'($urandom_range(1, NumIds)), t0);
    end

    // Pause until everything is back, then expire the whole table and clear it
    wait_idle();
    send_req(FUNC_TICK, '0, t0 + 32'd70000);
    for (int unsigned k = 1; k <= NumIds; k++) send_req(FUNC_END, IdW'(k), t0);
    send_req(FUNC_TICK, '0, t0 + 32'd70001);
    send_req(FUNC_LOOKUP, 6'd1, t0);

    wait_idle();
    if (fail_count == 0 && pending == 0) begin
      $display("request_id_allocator_timeout_tb OK");
    end else begin
      $display("request_id_allocator_timeout_tb NOT OK");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/ridat_pkg.sv
rtl/ridat_req_if.sv
rtl/ridat_rsp_if.sv
rtl/ridat_alu.sv
rtl/request_id_allocator_timeout.sv
test/request_id_allocator_timeout_checker.sv
test/request_id_allocator_timeout_tb.sv
